@@ src/blps_pkg.sv @@
// Shared types and constants of the buzzer / LED pattern sequencer.
// No dependencies; used by every module in src.
package blps_pkg;

    localparam int TIME_WIDTH_DEF = 16;
    localparam int REG_WIDTH      = 16;
    localparam int CNT_WIDTH      = 4;
    localparam int IDX_WIDTH      = 4;

    // Register indexes
    localparam logic [IDX_WIDTH-1:0] REG_HIGH_TONE  = 4'd0;
    localparam logic [IDX_WIDTH-1:0] REG_LOW_TONE   = 4'd1;
    localparam logic [IDX_WIDTH-1:0] REG_BEEP_ON    = 4'd2;
    localparam logic [IDX_WIDTH-1:0] REG_BEEP_GAP   = 4'd3;
    localparam logic [IDX_WIDTH-1:0] REG_GROUP_GAP  = 4'd4;
    localparam logic [IDX_WIDTH-1:0] REG_BEEPS      = 4'd5;
    localparam logic [IDX_WIDTH-1:0] REG_ONESHOT    = 4'd6;
    localparam logic [IDX_WIDTH-1:0] REG_BLINK      = 4'd7;

    // Reset values
    localparam logic [REG_WIDTH-1:0] HIGH_TONE_RST = 16'd667;
    localparam logic [REG_WIDTH-1:0] LOW_TONE_RST  = 16'd3333;
    localparam logic [REG_WIDTH-1:0] BEEP_ON_RST   = 16'd100;
    localparam logic [REG_WIDTH-1:0] BEEP_GAP_RST  = 16'd100;
    localparam logic [REG_WIDTH-1:0] GROUP_GAP_RST = 16'd500;
    localparam logic [CNT_WIDTH-1:0] BEEPS_RST     = 4'd3;
    localparam logic [REG_WIDTH-1:0] ONESHOT_RST   = 16'd1000;
    localparam logic [REG_WIDTH-1:0] BLINK_RST     = 16'd500;

    typedef struct packed {
        logic [REG_WIDTH-1:0] high_tone_period;
        logic [REG_WIDTH-1:0] low_tone_period;
        logic [REG_WIDTH-1:0] beep_on_time;
        logic [REG_WIDTH-1:0] beep_gap_time;
        logic [REG_WIDTH-1:0] group_gap_time;
        logic [CNT_WIDTH-1:0] beeps_per_group;
        logic [REG_WIDTH-1:0] oneshot_time;
        logic [REG_WIDTH-1:0] blink_time;
    } t_cfg;

    typedef struct packed {
        logic                 buzzer_on;
        logic [REG_WIDTH-1:0] tone_period;
        logic                 request_done;
    } t_buz_res;

endpackage

@@ src/blps_cfg.sv @@
// Configuration register file of the sequencer.
// Depends on blps_pkg.
module blps_cfg
    import blps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_WIDTH-1:0] i_cfg_index,
    input  logic [REG_WIDTH-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_tone_period <= HIGH_TONE_RST;
            r_cfg.low_tone_period  <= LOW_TONE_RST;
            r_cfg.beep_on_time     <= BEEP_ON_RST;
            r_cfg.beep_gap_time    <= BEEP_GAP_RST;
            r_cfg.group_gap_time   <= GROUP_GAP_RST;
            r_cfg.beeps_per_group  <= BEEPS_RST;
            r_cfg.oneshot_time     <= ONESHOT_RST;
            r_cfg.blink_time       <= BLINK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HIGH_TONE: r_cfg.high_tone_period <= i_cfg_data;
                REG_LOW_TONE:  r_cfg.low_tone_period  <= i_cfg_data;
                REG_BEEP_ON:   r_cfg.beep_on_time     <= i_cfg_data;
                REG_BEEP_GAP:  r_cfg.beep_gap_time    <= i_cfg_data;
                REG_GROUP_GAP: r_cfg.group_gap_time   <= i_cfg_data;
                REG_BEEPS:     r_cfg.beeps_per_group  <= i_cfg_data[CNT_WIDTH-1:0];
                REG_ONESHOT:   r_cfg.oneshot_time     <= i_cfg_data;
                REG_BLINK:     r_cfg.blink_time       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/blps_buzzer.sv @@
// Buzzer sequencing: warning beep groups and one-shot beep/bop tones.
// Depends on blps_pkg. State advances on each accepted tick.
module blps_buzzer
    import blps_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_warning_active,
    input  logic     i_beep_request,
    input  logic     i_bop_request,
    input  t_cfg     i_cfg,
    output t_buz_res o_res
);

    localparam int CW = (TIME_WIDTH > REG_WIDTH) ? TIME_WIDTH : REG_WIDTH;
    localparam logic [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};

    logic                  r_warn_run, n_warn_run;
    logic                  r_in_beep, n_in_beep;
    logic [CNT_WIDTH-1:0]  r_beeps_done, n_beeps_done;
    logic [TIME_WIDTH-1:0] r_phase_el, n_phase_el;
    logic                  r_os_run, n_os_run;
    logic [TIME_WIDTH-1:0] r_os_el, n_os_el;
    logic                  r_beep_pend, n_beep_pend;
    logic                  r_bop_pend, n_bop_pend;
    logic [REG_WIDTH-1:0]  r_period, n_period;
    logic                  r_pwm, n_pwm;
    logic                  n_done;

    logic [TIME_WIDTH-1:0] phase_inc, os_inc;
    logic [REG_WIDTH-1:0]  dur;

    assign phase_inc = (r_phase_el == TMAX) ? TMAX : r_phase_el + 1'b1;

    always_comb begin
        n_warn_run   = r_warn_run;
        n_in_beep    = r_in_beep;
        n_beeps_done = r_beeps_done;
        n_phase_el   = r_phase_el;
        n_os_run     = r_os_run;
        n_os_el      = r_os_el;
        n_beep_pend  = r_beep_pend | i_beep_request;
        n_bop_pend   = r_bop_pend | i_bop_request;
        n_period     = r_period;
        n_pwm        = r_pwm;
        n_done       = 1'b0;
        os_inc       = '0;

        if (r_in_beep)
            dur = i_cfg.beep_on_time;
        else if (r_beeps_done < i_cfg.beeps_per_group)
            dur = i_cfg.beep_gap_time;
        else
            dur = i_cfg.group_gap_time;

        if (i_warning_active) begin
            if (!r_warn_run) begin
                n_period     = i_cfg.high_tone_period;
                n_pwm        = 1'b1;
                n_warn_run   = 1'b1;
                n_phase_el   = '0;
                n_beeps_done = '0;
                n_in_beep    = 1'b1;
            end else if (CW'(phase_inc) >= CW'(dur)) begin
                n_phase_el = '0;
                if (r_in_beep) begin
                    n_pwm        = 1'b0;
                    n_beeps_done = r_beeps_done + 1'b1;
                    n_in_beep    = 1'b0;
                end else begin
                    if (r_beeps_done >= i_cfg.beeps_per_group)
                        n_beeps_done = '0;
                    n_pwm     = 1'b1;
                    n_in_beep = 1'b1;
                end
            end else begin
                n_phase_el = phase_inc;
            end
        end else begin
            // leaving warning restarts any one-shot in progress from zero
            if (r_warn_run) begin
                n_warn_run   = 1'b0;
                n_os_run     = 1'b0;
                n_os_el      = '0;
                n_beeps_done = '0;
                n_in_beep    = 1'b0;
                n_pwm        = 1'b0;
            end
            if (n_beep_pend || n_bop_pend) begin
                if (!n_os_run) begin
                    n_os_run = 1'b1;
                    n_os_el  = '0;
                    n_period = n_beep_pend ? i_cfg.high_tone_period
                                           : i_cfg.low_tone_period;
                    n_pwm    = 1'b1;
                end else begin
                    os_inc = (r_os_el == TMAX) ? TMAX : r_os_el + 1'b1;
                    if (CW'(os_inc) > CW'(i_cfg.oneshot_time)) begin
                        n_os_run    = 1'b0;
                        n_os_el     = '0;
                        n_beep_pend = 1'b0;
                        n_bop_pend  = 1'b0;
                        n_pwm       = 1'b0;
                        n_done      = 1'b1;
                    end else begin
                        n_os_el = os_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_run   <= 1'b0;
            r_in_beep    <= 1'b0;
            r_beeps_done <= '0;
            r_phase_el   <= '0;
            r_os_run     <= 1'b0;
            r_os_el      <= '0;
            r_beep_pend  <= 1'b0;
            r_bop_pend   <= 1'b0;
            r_period     <= HIGH_TONE_RST;
            r_pwm        <= 1'b0;
        end else if (i_adv) begin
            r_warn_run   <= n_warn_run;
            r_in_beep    <= n_in_beep;
            r_beeps_done <= n_beeps_done;
            r_phase_el   <= n_phase_el;
            r_os_run     <= n_os_run;
            r_os_el      <= n_os_el;
            r_beep_pend  <= n_beep_pend;
            r_bop_pend   <= n_bop_pend;
            r_period     <= n_period;
            r_pwm        <= n_pwm;
        end
    end

    assign o_res.buzzer_on    = n_pwm;
    assign o_res.tone_period  = n_period;
    assign o_res.request_done = n_done;

endmodule

@@ src/blps_led.sv @@
// Status LED: blinks while scanning, else follows tag approval.
// Depends on blps_pkg.
module blps_led
    import blps_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_scan_active,
    input  logic                 i_tag_approved,
    input  logic [REG_WIDTH-1:0] i_blink_time,
    output logic                 o_led_next
);

    localparam int CW = (TIME_WIDTH > REG_WIDTH) ? TIME_WIDTH : REG_WIDTH;
    localparam logic [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};

    logic                  r_armed, n_armed;
    logic [TIME_WIDTH-1:0] r_elapsed, n_elapsed;
    logic                  r_led, n_led;
    logic [TIME_WIDTH-1:0] el_inc;

    assign el_inc = (r_elapsed == TMAX) ? TMAX : r_elapsed + 1'b1;

    always_comb begin
        n_armed   = r_armed;
        n_elapsed = r_elapsed;
        n_led     = r_led;
        if (i_scan_active) begin
            if (!r_armed) begin
                n_armed   = 1'b1;
                n_elapsed = '0;
            end else if (CW'(el_inc) >= CW'(i_blink_time)) begin
                n_armed   = 1'b0;
                n_elapsed = '0;
                n_led     = !r_led;
            end else begin
                n_elapsed = el_inc;
            end
        end else begin
            // blink timer is held while not scanning; the LED follows tag approval
            n_led = i_tag_approved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_elapsed <= '0;
            r_led     <= 1'b0;
        end else if (i_adv) begin
            r_armed   <= n_armed;
            r_elapsed <= n_elapsed;
            r_led     <= n_led;
        end
    end

    assign o_led_next = n_led;

endmodule

@@ src/buzzer_led_pattern_sequencer_top.sv @@
// Buzzer and status LED pattern sequencer, one input transfer per millisecond tick.
// Each accepted tick produces exactly one result in the following cycle. The sequencing state
// and the result register update together on the accepting edge. A new tick is accepted
// in every cycle in which the result register is empty or its result transfers on the
// same edge, so ticks run back to back; the input stalls only while a result is held
// by the output stall. Elapsed counters are TIME_WIDTH bits and saturate. Registers
// are written through the plain write port; the user writes them only while idle, which the block does not enforce.
// Depends on blps_pkg, blps_cfg, blps_buzzer and blps_led.
module buzzer_led_pattern_sequencer_top
    import blps_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_WIDTH-1:0] i_cfg_index,
    input  logic [REG_WIDTH-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_warning_active,
    input  logic                 i_beep_request,
    input  logic                 i_bop_request,
    input  logic                 i_scan_active,
    input  logic                 i_tag_approved,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_buzzer_on,
    output logic [15:0]          o_tone_period,
    output logic [14:0]          o_tone_compare,
    output logic                 o_status_led,
    output logic                 o_request_done
);

    t_cfg     cfg;
    t_buz_res buz_res;
    logic     led_next;
    logic     adv;

    logic                 r_out_valid;
    t_buz_res             r_buz;
    logic                 r_led;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign adv        = i_in_valid & !o_in_stall;

    blps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    blps_buzzer #(.TIME_WIDTH(TIME_WIDTH)) u_buzzer (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_warning_active (i_warning_active),
        .i_beep_request   (i_beep_request),
        .i_bop_request    (i_bop_request),
        .i_cfg            (cfg),
        .o_res            (buz_res)
    );

    blps_led #(.TIME_WIDTH(TIME_WIDTH)) u_led (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_scan_active  (i_scan_active),
        .i_tag_approved (i_tag_approved),
        .i_blink_time   (cfg.blink_time),
        .o_led_next     (led_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_buz <= buz_res;
            r_led <= led_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_buzzer_on    = r_buz.buzzer_on;
    assign o_tone_period  = r_buz.tone_period;
    assign o_tone_compare = r_buz.tone_period[REG_WIDTH-1:1];
    assign o_status_led   = r_led;
    assign o_request_done = r_buz.request_done;

endmodule
